>>> sv/oale_pkg.sv
package oale_pkg;

	localparam int DEF_CAPACITY = 64;
	localparam int DATA_W       = 32;
	localparam int POS_W        = 6;
	localparam int CMD_W        = 3;
	localparam int STATUS_W     = 2;
	localparam int COUNT_W      = 7;

	localparam logic [CMD_W-1:0] CMD_INSERT    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_OVERWRITE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_DELETE    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_SEARCH    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ      = 3'd4;

	localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_BAD  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]         command;
		logic [POS_W-1:0]         position;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0]      status;
		logic [POS_W-1:0]         index;
		logic signed [DATA_W-1:0] read_value;
		logic [COUNT_W-1:0]       count;
	} rsp_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_INSERT,
		OP_WRITE,
		OP_DELETE,
		OP_MATCH
	} cell_op_t;

	typedef struct packed {
		cell_op_t           op;
		logic [POS_W-1:0]   pos;
		logic [DATA_W-1:0]  val;
	} cell_ctl_t;

endpackage

>>> sv/oale_stream_if.sv
interface oale_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> sv/oale_cell.sv
module oale_cell
	import oale_pkg::*;
#(
	parameter int INDEX = 0,
	parameter int IDX_W = 6
) (
	input  logic              clk,
	input  cell_ctl_t         ctl,
	input  logic [DATA_W-1:0] left,
	input  logic [DATA_W-1:0] right,
	output logic [DATA_W-1:0] entry,
	output logic              match
);
	localparam int CW = IDX_W + POS_W;

	logic at_pos;
	logic above_pos;

	assign at_pos    = CW'(ctl.pos) == CW'(INDEX);
	assign above_pos = CW'(INDEX) > CW'(ctl.pos);

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_INSERT: begin
				if (above_pos) begin
					entry <= left;
				end else if (at_pos) begin
					entry <= ctl.val;
				end
			end
			OP_WRITE: begin
				if (at_pos) begin
					entry <= ctl.val;
				end
			end
			OP_DELETE: begin
				if (above_pos || at_pos) begin
					entry <= right;
				end
			end
			OP_MATCH: begin
				match <= entry == ctl.val;
			end
			default: begin
			end
		endcase
	end

endmodule

>>> sv/ordered_array_list_engine.sv
// Insert, overwrite, delete and read register their result beat at the accepting edge; a new
// command may follow in the next cycle if the result beat is taken in that cycle.
// Search compares every cell at the accepting edge, then walks the match flags one cell a
// cycle from index 0, stopping at the first hit or, for a miss, at the entry count.
// Reset clears the count and the handshake state; cell contents are left as they are.
module ordered_array_list_engine
	import oale_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic               clk,
	input  logic               arst_n,
	oale_stream_if.sink        req,
	oale_stream_if.source      rsp
);
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int PW    = CNT_W + POS_W;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  scan_q;
	logic [DATA_W-1:0] key_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic [DATA_W-1:0] entry_w [CAPACITY];
	logic [DATA_W-1:0] left_w [CAPACITY];
	logic [DATA_W-1:0] right_w [CAPACITY];
	logic              match_w [CAPACITY];

	cell_ctl_t         ctl;
	req_t              rq;
	logic              slot_free;
	logic              accept;
	logic              pos_le;
	logic              pos_lt;
	logic              full;
	logic [PW-1:0]     pos_ext;
	logic [IDX_W-1:0]  rd_idx;
	rsp_t              res;
	logic [CNT_W-1:0]  cnt_next;
	logic              scan_end;
	logic              scan_hit;
	logic [PW-1:0]     scan_ext;
	logic [PW-1:0]     cnt_ext;

	assign rq        = req.data;
	assign slot_free = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE) && slot_free;
	assign accept    = req.valid && req.ready;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	assign pos_ext  = PW'(rq.position);
	assign cnt_ext  = PW'(cnt_q);
	assign pos_le   = pos_ext <= cnt_ext;
	assign pos_lt   = pos_ext < cnt_ext;
	assign full     = cnt_q == CNT_W'(CAPACITY);
	assign rd_idx   = pos_ext[IDX_W-1:0];
	assign scan_ext = PW'(scan_q);
	assign scan_end = scan_q >= cnt_q;
	assign scan_hit = match_w[scan_q[IDX_W-1:0]];

	always_comb begin
		ctl.op   = OP_HOLD;
		ctl.pos  = rq.position;
		ctl.val  = rq.value;
		cnt_next = cnt_q;
		res.status     = STATUS_BAD;
		res.index      = rq.position;
		res.read_value = '0;
		unique case (rq.command)
			CMD_INSERT: begin
				if (!full && pos_le) begin
					ctl.op     = OP_INSERT;
					cnt_next   = cnt_q + CNT_W'(1);
					res.status = STATUS_OK;
				end
			end
			CMD_OVERWRITE: begin
				if (pos_lt) begin
					ctl.op     = OP_WRITE;
					res.status = STATUS_OK;
				end
			end
			CMD_DELETE: begin
				if (pos_lt) begin
					ctl.op     = OP_DELETE;
					cnt_next   = cnt_q - CNT_W'(1);
					res.status = STATUS_OK;
				end
			end
			CMD_SEARCH: begin
				ctl.op = OP_MATCH;
			end
			CMD_READ: begin
				if (pos_lt) begin
					res.read_value = entry_w[rd_idx];
					res.status     = STATUS_OK;
				end
			end
			default: begin
			end
		endcase
		res.count = COUNT_W'(cnt_next);
		if (!accept) begin
			ctl.op = OP_HOLD;
		end
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		if (g == 0) begin : g_first
			assign left_w[g] = '0;
		end else begin : g_mid
			assign left_w[g] = entry_w[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign right_w[g] = entry_w[g];
		end else begin : g_inner
			assign right_w[g] = entry_w[g+1];
		end

		oale_cell #(
			.INDEX (g),
			.IDX_W (IDX_W)
		) u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.left  (left_w[g]),
			.right (right_w[g]),
			.entry (entry_w[g]),
			.match (match_w[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			scan_q      <= '0;
			key_q       <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (rq.command == CMD_SEARCH) begin
							state_q <= ST_SCAN;
							scan_q  <= '0;
							key_q   <= rq.value;
						end else begin
							cnt_q                <= cnt_next;
							rsp_valid_q          <= 1'b1;
							rsp_q.status         <= res.status;
							rsp_q.index          <= res.index;
							rsp_q.read_value     <= res.read_value;
							rsp_q.count          <= res.count;
						end
					end
				end
				ST_SCAN: begin
					if (scan_end || scan_hit) begin
						if (slot_free) begin
							state_q          <= ST_IDLE;
							rsp_valid_q      <= 1'b1;
							rsp_q.count      <= cnt_ext[COUNT_W-1:0];
							if (scan_end) begin
								rsp_q.status     <= STATUS_MISS;
								rsp_q.index      <= '0;
								rsp_q.read_value <= '0;
							end else begin
								rsp_q.status     <= STATUS_OK;
								rsp_q.index      <= scan_ext[POS_W-1:0];
								rsp_q.read_value <= key_q;
							end
						end
					end else begin
						scan_q <= scan_q + CNT_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("entry count exceeds capacity");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && ctl.op == OP_INSERT) |=> cnt_q == $past(cnt_q) + CNT_W'(1))
		else $error("insert did not grow the list by one");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> scan_q <= cnt_q)
		else $error("search walked past the end of the list");

	a_scan_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |=> $stable(cnt_q))
		else $error("count changed during a search");
`endif

endmodule
